@@ hw/rtl/limit_order_book_matcher_core_macros.svh @@
// Assertion macros shared by the matcher RTL.
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
// Property checked on every clock edge outside reset.
`define LOB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define LOB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hw/rtl/lobm_pkg.sv @@
// Package with the shared types, constants and codes of the order book matcher.
package lobm_pkg;
    localparam int MaxOrders = 32;

    localparam logic CmdAdd = 1'b0;
    localparam logic CmdCancel = 1'b1;
    localparam logic SideBuy = 1'b0;
    localparam logic SideSell = 1'b1;
    localparam logic KindLimit = 1'b0;
    localparam logic KindMarket = 1'b1;

    localparam logic [2:0] StRested = 3'd0;
    localparam logic [2:0] StDone = 3'd1;
    localparam logic [2:0] StCancelled = 3'd2;
    localparam logic [2:0] StNotFound = 3'd3;
    localparam logic [2:0] StFull = 3'd4;
    localparam logic [2:0] StDuplicate = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SEARCH,
        S_CHECK,
        S_TRADE,
        S_REST,
        S_BOOK,
        S_STATUS
    } t_state;

    typedef enum logic [2:0] {
        SCAN_ID,
        SCAN_MAKER,
        SCAN_BOOK
    } t_scan;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        t_scan      scan_mode;
        logic       cancel_hit;
        logic       fill;
        logic       rest;
        logic       emit_trade;
        logic       emit_status;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic is_cancel;
        logic is_market;
        logic id_hit;
        logic full;
        logic qty_zero;
        logic maker_found;
        logic price_ok;
        logic trade_cnt_max;
        logic out_busy;
    } t_sts;
endpackage

@@ hw/rtl/lobm_ctrl.sv @@
// Controller state machine that sequences lookups, fills, resting and status beats.
module lobm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  lobm_pkg::t_sts   i_sts,
    output lobm_pkg::t_cmd   o_cmd
);
    lobm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lobm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lobm_pkg::S_IDLE: if (i_valid) n_state = lobm_pkg::S_LOOKUP;
            lobm_pkg::S_LOOKUP: if (i_sts.scan_done) n_state = lobm_pkg::S_DECIDE;
            lobm_pkg::S_DECIDE: begin
                priority if (i_sts.is_cancel) n_state = lobm_pkg::S_BOOK;
                else if (i_sts.id_hit) n_state = lobm_pkg::S_BOOK;
                else if (!i_sts.is_market && i_sts.full) n_state = lobm_pkg::S_BOOK;
                else n_state = lobm_pkg::S_SEARCH;
            end
            lobm_pkg::S_SEARCH: begin
                priority if (i_sts.qty_zero || i_sts.trade_cnt_max) n_state = lobm_pkg::S_REST;
                else n_state = lobm_pkg::S_CHECK;
            end
            lobm_pkg::S_CHECK: begin
                priority if (!i_sts.scan_done) n_state = lobm_pkg::S_CHECK;
                else if (i_sts.maker_found && i_sts.price_ok) n_state = lobm_pkg::S_TRADE;
                else n_state = lobm_pkg::S_REST;
            end
            lobm_pkg::S_TRADE: if (!i_sts.out_busy) n_state = lobm_pkg::S_SEARCH;
            lobm_pkg::S_REST: n_state = lobm_pkg::S_BOOK;
            lobm_pkg::S_BOOK: if (i_sts.scan_done) n_state = lobm_pkg::S_STATUS;
            lobm_pkg::S_STATUS: if (!i_sts.out_busy) n_state = lobm_pkg::S_IDLE;
            default: n_state = lobm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.scan_mode = lobm_pkg::SCAN_ID;
        o_stall = 1'b1;
        unique case (r_state)
            lobm_pkg::S_IDLE: begin
                o_stall = 1'b0;
                o_cmd.load = i_valid;
                o_cmd.scan_start = i_valid;
            end
            lobm_pkg::S_LOOKUP: o_cmd.scan_mode = lobm_pkg::SCAN_ID;
            lobm_pkg::S_DECIDE: begin
                o_cmd.cancel_hit = i_sts.is_cancel && i_sts.id_hit;
                o_cmd.scan_start = 1'b1;
                if (i_sts.is_cancel || i_sts.id_hit
                        || (!i_sts.is_market && i_sts.full)) begin
                    o_cmd.scan_mode = lobm_pkg::SCAN_BOOK;
                end else begin
                    o_cmd.scan_mode = lobm_pkg::SCAN_MAKER;
                end
            end
            lobm_pkg::S_SEARCH: begin
                o_cmd.scan_mode = lobm_pkg::SCAN_MAKER;
                o_cmd.scan_start = 1'b1;
            end
            lobm_pkg::S_CHECK: o_cmd.scan_mode = lobm_pkg::SCAN_MAKER;
            lobm_pkg::S_TRADE: begin
                o_cmd.emit_trade = !i_sts.out_busy;
                o_cmd.fill = !i_sts.out_busy;
            end
            lobm_pkg::S_REST: begin
                o_cmd.rest = 1'b1;
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode = lobm_pkg::SCAN_BOOK;
            end
            lobm_pkg::S_BOOK: o_cmd.scan_mode = lobm_pkg::SCAN_BOOK;
            lobm_pkg::S_STATUS: o_cmd.emit_status = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

`include "limit_order_book_matcher_core_macros.svh"
    `LOB_ASSERT(a_stall_busy, i_clk, i_rst_n, (r_state != lobm_pkg::S_IDLE) |-> o_stall, "accepted while busy")
    `LOB_ASSERT(a_trade_gate, i_clk, i_rst_n, o_cmd.emit_trade |-> (r_state == lobm_pkg::S_TRADE), "trade outside TRADE")
    `LOB_ASSERT(a_one_emit, i_clk, i_rst_n, !(o_cmd.emit_trade && o_cmd.emit_status), "two beats at once")
endmodule

@@ hw/rtl/lobm_dp.sv @@
// Datapath holding the order table, the sequential scanner and the output register.
module lobm_dp #(
    parameter int MAX_ORDERS = lobm_pkg::MaxOrders
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lobm_pkg::t_cmd i_cmd,
    output lobm_pkg::t_sts o_sts,
    input  logic           i_command,
    input  logic [31:0]    i_order_id,
    input  logic           i_side,
    input  logic           i_order_kind,
    input  logic [31:0]    i_limit_price,
    input  logic [31:0]    i_quantity,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_item_kind,
    output logic [31:0]    o_maker_id,
    output logic [31:0]    o_taker_id,
    output logic [31:0]    o_trade_price,
    output logic [31:0]    o_trade_qty,
    output logic [2:0]     o_status,
    output logic [31:0]    o_best_bid,
    output logic           o_bid_valid,
    output logic [31:0]    o_best_ask,
    output logic           o_ask_valid,
    output logic           o_last
);
    localparam int IW = $clog2(MAX_ORDERS);
    localparam int CW = $clog2(MAX_ORDERS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_ORDERS);

    logic [MAX_ORDERS-1:0] r_valid;
    logic                  r_eside [MAX_ORDERS];
    logic [31:0]           r_eprice [MAX_ORDERS];
    logic [31:0]           r_erem [MAX_ORDERS];
    logic [31:0]           r_eid [MAX_ORDERS];
    logic [31:0]           r_earr [MAX_ORDERS];
    logic [31:0]           r_arrival;

    logic        r_cmd, r_side, r_kind;
    logic [31:0] r_id, r_price, r_qty;

    logic          r_scanning;
    logic [CW-1:0] r_ptr;
    logic [IW-1:0] r_rd;
    logic          r_rd_ok;
    logic          r_e_ok;
    logic [IW-1:0] r_e_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [31:0]   r_best_price, r_best_arr, r_best_rem, r_best_id;
    logic          r_bid_ok, r_ask_ok;
    logic [31:0]   r_bid, r_ask;
    logic [CW-1:0] r_trades;
    lobm_pkg::t_scan r_mode;

    logic          e_ok, e_side;
    logic [31:0]   e_price, e_rem, e_id, e_arr;
    logic [31:0]   fill;
    logic          better;
    logic [IW-1:0] free_idx;
    logic          free_ok;
    logic          do_rest;

    always_ff @(posedge i_clk) begin
        e_ok <= r_valid[r_rd];
        e_side <= r_eside[r_rd];
        e_price <= r_eprice[r_rd];
        e_rem <= r_erem[r_rd];
        e_id <= r_eid[r_rd];
        e_arr <= r_earr[r_rd];
    end

    always_comb begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int k = MAX_ORDERS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = IW'(k);
                free_ok = 1'b1;
            end
        end
    end

    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (e_price == r_best_price) begin
            better = e_arr < r_best_arr;
        end else if (r_side == lobm_pkg::SideSell) begin
            better = e_price > r_best_price;
        end else begin
            better = e_price < r_best_price;
        end
    end

    assign fill = (r_qty < r_best_rem) ? r_qty : r_best_rem;
    assign do_rest = i_cmd.rest && r_qty != 32'd0 && r_kind == lobm_pkg::KindLimit
        && free_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_id <= i_order_id;
            r_side <= i_side;
            r_kind <= i_order_kind;
            r_price <= i_limit_price;
            r_qty <= i_quantity;
            r_trades <= '0;
        end
        if (i_cmd.fill) begin
            r_qty <= r_qty - fill;
            r_erem[r_best] <= r_best_rem - fill;
            r_trades <= r_trades + CW'(1);
        end
        if (do_rest) begin
            r_eside[free_idx] <= r_side;
            r_eprice[free_idx] <= r_price;
            r_erem[free_idx] <= r_qty;
            r_eid[free_idx] <= r_id;
            r_earr[free_idx] <= r_arrival;
        end
        if (i_cmd.scan_start) begin
            r_ptr <= '0;
            r_mode <= i_cmd.scan_mode;
            r_found <= 1'b0;
            r_bid_ok <= 1'b0;
            r_ask_ok <= 1'b0;
            if (i_cmd.load) r_hit <= 1'b0;
        end else if (r_scanning) begin
            if (r_e_ok && e_ok) begin
                unique case (r_mode)
                    lobm_pkg::SCAN_ID: begin
                        if (e_id == r_id && !r_hit) begin
                            r_hit <= 1'b1;
                            r_hit_idx <= r_e_idx;
                        end
                    end
                    lobm_pkg::SCAN_MAKER: begin
                        if (e_side != r_side && better) begin
                            r_found <= 1'b1;
                            r_best <= r_e_idx;
                            r_best_price <= e_price;
                            r_best_arr <= e_arr;
                            r_best_rem <= e_rem;
                            r_best_id <= e_id;
                        end
                    end
                    default: begin
                        if (e_side == lobm_pkg::SideBuy) begin
                            if (!r_bid_ok || e_price > r_bid) begin
                                r_bid <= e_price;
                            end
                            r_bid_ok <= 1'b1;
                        end else begin
                            if (!r_ask_ok || e_price < r_ask) begin
                                r_ask <= e_price;
                            end
                            r_ask_ok <= 1'b1;
                        end
                    end
                endcase
            end
            if (r_ptr != MaxCnt) r_ptr <= r_ptr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_arrival <= '0;
            r_scanning <= 1'b0;
            r_rd_ok <= 1'b0;
            r_rd <= '0;
            r_e_ok <= 1'b0;
            r_e_idx <= '0;
        end else begin
            r_e_ok <= r_scanning && !i_cmd.scan_start && r_rd_ok;
            r_e_idx <= r_rd;
            if (i_cmd.scan_start) begin
                r_scanning <= 1'b1;
                r_rd_ok <= 1'b0;
            end else if (r_scanning) begin
                r_rd_ok <= (r_ptr < MaxCnt);
                r_rd <= r_ptr[IW-1:0];
                if (r_ptr == MaxCnt) r_scanning <= r_rd_ok || r_e_ok;
            end
            if (i_cmd.cancel_hit) r_valid[r_hit_idx] <= 1'b0;
            if (i_cmd.fill && fill == r_best_rem) r_valid[r_best] <= 1'b0;
            if (do_rest) begin
                r_valid[free_idx] <= 1'b1;
                r_arrival <= r_arrival + 32'd1;
            end
        end
    end

    logic [2:0] r_stat;
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start && i_cmd.scan_mode == lobm_pkg::SCAN_BOOK && !i_cmd.rest) begin
            priority if (r_cmd == lobm_pkg::CmdCancel)
                r_stat <= r_hit ? lobm_pkg::StCancelled : lobm_pkg::StNotFound;
            else if (r_hit) r_stat <= lobm_pkg::StDuplicate;
            else r_stat <= lobm_pkg::StFull;
        end else if (i_cmd.rest) begin
            priority if (r_qty == 32'd0 || r_kind == lobm_pkg::KindMarket)
                r_stat <= lobm_pkg::StDone;
            else if (free_ok) r_stat <= lobm_pkg::StRested;
            else r_stat <= lobm_pkg::StFull;
        end
    end

    assign o_sts.scan_done = r_scanning && !i_cmd.scan_start && r_ptr == MaxCnt
        && !r_rd_ok && !r_e_ok;
    assign o_sts.is_cancel = r_cmd;
    assign o_sts.is_market = r_kind;
    assign o_sts.id_hit = r_hit;
    assign o_sts.full = !free_ok;
    assign o_sts.qty_zero = (r_qty == 32'd0);
    assign o_sts.maker_found = r_found;
    assign o_sts.price_ok = (r_kind == lobm_pkg::KindMarket)
        || (r_side == lobm_pkg::SideBuy && r_price >= r_best_price)
        || (r_side == lobm_pkg::SideSell && r_price <= r_best_price);
    assign o_sts.trade_cnt_max = (r_trades == MaxCnt);
    assign o_sts.out_busy = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_trade || i_cmd.emit_status) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_trade) begin
            o_item_kind <= 1'b0;
            o_maker_id <= r_best_id;
            o_taker_id <= r_id;
            o_trade_price <= r_best_price;
            o_trade_qty <= fill;
            o_status <= lobm_pkg::StRested;
            o_best_bid <= '0;
            o_bid_valid <= 1'b0;
            o_best_ask <= '0;
            o_ask_valid <= 1'b0;
            o_last <= 1'b0;
        end else if (i_cmd.emit_status) begin
            o_item_kind <= 1'b1;
            o_maker_id <= '0;
            o_taker_id <= r_id;
            o_trade_price <= '0;
            o_trade_qty <= '0;
            o_status <= r_stat;
            o_best_bid <= r_bid_ok ? r_bid : 32'd0;
            o_bid_valid <= r_bid_ok;
            o_best_ask <= r_ask_ok ? r_ask : 32'd0;
            o_ask_valid <= r_ask_ok;
            o_last <= 1'b1;
        end
    end

`include "limit_order_book_matcher_core_macros.svh"
    `LOB_ASSERT(a_fill_found, i_clk, i_rst_n, i_cmd.fill |-> (r_found && r_valid[r_best]), "no maker")
    `LOB_ASSERT(a_fill_le, i_clk, i_rst_n, i_cmd.fill |-> (fill <= r_qty), "fill above quantity")
    `LOB_ASSERT(a_trade_cap, i_clk, i_rst_n, i_cmd.fill |-> (r_trades < MaxCnt), "too many trades")
endmodule

@@ hw/rtl/limit_order_book_matcher_core.sv @@
// Top level of the limit order book matcher with price-time priority.
// Channel | Direction | Handshake
// input   | in        | i_valid / o_stall
// output  | out       | o_valid / i_stall
// Each scan reads the table one entry a cycle through a registered read.
// An add with F fills takes an id scan, up to F+1 maker scans and a final book scan for best
// bid and ask; a cancel or a rejected add takes two scans.
// Reset is synchronous and active low; it clears the valid bits and the arrival counter.
// A stall on the output holds the pending beat and holds the controller in its trade or status state.
module limit_order_book_matcher_core #(
    parameter int MAX_ORDERS = lobm_pkg::MaxOrders
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic        i_order_kind,
    input  logic [31:0] i_limit_price,
    input  logic [31:0] i_quantity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_item_kind,
    output logic [31:0] o_maker_id,
    output logic [31:0] o_taker_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_qty,
    output logic [2:0]  o_status,
    output logic [31:0] o_best_bid,
    output logic        o_bid_valid,
    output logic [31:0] o_best_ask,
    output logic        o_ask_valid,
    output logic        o_last
);
    lobm_pkg::t_cmd cmd;
    lobm_pkg::t_sts sts;

    lobm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    lobm_dp #(.MAX_ORDERS(MAX_ORDERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_command(i_command), .i_order_id(i_order_id), .i_side(i_side),
        .i_order_kind(i_order_kind), .i_limit_price(i_limit_price),
        .i_quantity(i_quantity), .o_valid(o_valid), .i_stall(i_stall),
        .o_item_kind(o_item_kind), .o_maker_id(o_maker_id), .o_taker_id(o_taker_id),
        .o_trade_price(o_trade_price), .o_trade_qty(o_trade_qty), .o_status(o_status),
        .o_best_bid(o_best_bid), .o_bid_valid(o_bid_valid), .o_best_ask(o_best_ask),
        .o_ask_valid(o_ask_valid), .o_last(o_last)
    );
endmodule
